>>> rtl/core/diff_drive_mixer_slew_limiter_core_assert.svh
// Assertion macros for the differential drive mixer core.
// Depends on nothing; included by the files that check their own logic.
`ifndef DIFF_DRIVE_MIXER_SLEW_LIMITER_CORE_ASSERT_SVH
`define DIFF_DRIVE_MIXER_SLEW_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DDMSL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ddmsl same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DDMSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ddmsl next-cycle check failed");

`endif

>>> rtl/core/ddmsl_pkg.sv
// Shared types, codes and constants of the differential drive mixer core.
// Holds the duty function that builds the constant lookup table; depends on nothing.
package ddmsl_pkg;

  localparam int PWM_BITS = 16;
  localparam int PWM_HZ   = 50;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] REG_SPEED_BIAS   = 2'd0;
  localparam logic [1:0] REG_SPEED_OFFSET = 2'd1;
  localparam logic [1:0] REG_MIN_SPEED    = 2'd2;
  localparam logic [1:0] REG_MAX_SPEED    = 2'd3;

  localparam logic [7:0] JOY_CENTER    = 8'd124;
  localparam logic [7:0] LEVEL_NEUTRAL = 8'd127;
  localparam logic [4:0] DWELL_TICKS   = 5'd20;

  localparam logic [7:0] MIN_SPEED_RESET = 8'h9C;  // -100
  localparam logic [6:0] MAX_SPEED_RESET = 7'd100;

  typedef struct packed {
    logic [7:0] bias;
    logic [7:0] offset;
    logic [7:0] speed_lo;
    logic [6:0] speed_hi;
  } cfg_t;

  typedef struct packed {
    logic       update;
    logic [7:0] level;
    logic [4:0] dwell;
  } ramp_t;

  localparam longint unsigned PWM_MAX     = (64'd1 << PWM_BITS) - 64'd1;
  localparam longint unsigned DUTY_DENOM  = 64'd10000000;

  // On-time of 1 ms plus 7.8 us per level, over the PWM period, in counts.
  function automatic logic [15:0] duty_of(int level);
    longint unsigned num;
    longint unsigned d;
    num = (64'd10000 + 64'd78 * longint'(level)) * longint'(PWM_HZ) * PWM_MAX;
    d = num / DUTY_DENOM;
    if (d > PWM_MAX) d = PWM_MAX;
    if (d > 64'hFFFF) d = 64'hFFFF;
    return d[15:0];
  endfunction

endpackage

>>> rtl/core/ddmsl_goal.sv
// Turns one mixed joystick value into a motor goal level.
// Scaling, dead zone, bias, offset and clamp; depends on ddmsl_pkg.
module ddmsl_goal (
  input  ddmsl_pkg::cfg_t    cfg,
  input  logic signed [9:0]  mixed,
  output logic [7:0]         goal
);

  logic signed [16:0] scaled;
  logic signed [7:0]  speed0;
  logic signed [10:0] speed1;
  logic signed [10:0] speed2;
  logic signed [10:0] speed3;
  logic signed [10:0] speed4;
  logic signed [10:0] bias;
  logic signed [10:0] offset;
  logic signed [10:0] lo;
  logic signed [10:0] hi;
  logic signed [10:0] level;

  assign bias   = $signed({{3{cfg.bias[7]}}, cfg.bias});
  assign offset = $signed({{3{cfg.offset[7]}}, cfg.offset});
  assign lo     = $signed({{3{cfg.speed_lo[7]}}, cfg.speed_lo});
  assign hi     = $signed({4'b0000, cfg.speed_hi});

  // Times 100 then an arithmetic shift by 9 floors the quotient by 512.
  assign scaled = $signed({{7{mixed[9]}}, mixed}) * 17'sd100;
  assign speed0 = scaled[16:9];

  always_comb begin
    speed1 = $signed({{3{speed0[7]}}, speed0});
    if (speed1 > -11'sd3 && speed1 < 11'sd3) speed1 = 11'sd0;

    speed2 = speed1;
    if (speed1 > 11'sd5 || speed1 < -11'sd5) speed2 = speed1 + bias;

    // The offset pushes away from zero but never carries a speed across it.
    speed3 = speed2;
    if (speed2 > 11'sd0) begin
      speed3 = speed2 + offset;
      if (speed3 < 11'sd0) speed3 = 11'sd0;
    end else if (speed2 < 11'sd0) begin
      speed3 = speed2 - offset;
      if (speed3 > 11'sd0) speed3 = 11'sd0;
    end

    speed4 = speed3;
    if (speed3 > hi) speed4 = hi;
    else if (speed3 < lo) speed4 = lo;

    level = $signed({3'b000, ddmsl_pkg::LEVEL_NEUTRAL}) - speed4;
  end

  assign goal = level[7:0];

endmodule

>>> rtl/core/ddmsl_ramp.sv
// One motor's slew step: moves the level one count toward its goal.
// Holds off stepping during the dwell after neutral; depends on ddmsl_pkg.
module ddmsl_ramp (
  input  logic [7:0]        goal,
  input  logic [7:0]        level,
  input  logic [4:0]        dwell,
  output ddmsl_pkg::ramp_t  step
);

  logic [7:0] level_moved;

  assign level_moved = (level < goal) ? level + 8'd1 : level - 8'd1;

  always_comb begin
    step.update = 1'b0;
    step.level  = level;
    step.dwell  = dwell;
    if (goal != level) begin
      if (dwell != 5'd0) begin
        step.dwell = dwell - 5'd1;
      end else begin
        step.update = 1'b1;
        step.level  = level_moved;
        if (level_moved == ddmsl_pkg::LEVEL_NEUTRAL) step.dwell = ddmsl_pkg::DWELL_TICKS;
      end
    end
  end

endmodule

>>> rtl/core/diff_drive_mixer_slew_limiter_core.sv
// Differential drive mixer with slew-limited motor levels and PWM duty lookup.
// The result of an accepted item is loaded into the output register as the item is taken.
// Throughput: one item per cycle unless out_ready stalls; in_ready is high whenever
// the output register is empty or being taken, so the goal mixer, the ramp step and
// the duty table all sit in the single stage in front of that register.
// Reset (synchronous): config to defaults, levels and goals 127, dwells 0, no result.
module diff_drive_mixer_slew_limiter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  vertical,
  input  logic [7:0]  horizontal,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        left_update,
  output logic [15:0] left_duty,
  output logic        right_update,
  output logic [15:0] right_duty,
  output logic [7:0]  left_level,
  output logic [7:0]  right_level
);

  ddmsl_pkg::cfg_t   cfg;
  logic [7:0]        left_current;
  logic [7:0]        right_current;
  logic [7:0]        left_goal;
  logic [7:0]        right_goal;
  logic [4:0]        left_dwell;
  logic [4:0]        right_dwell;

  logic              in_fire;
  logic              is_tick;
  logic signed [9:0] vert_c;
  logic signed [9:0] horiz_c;
  logic signed [9:0] mix_sum;
  logic signed [9:0] mix_diff;
  logic [7:0]        left_goal_next;
  logic [7:0]        right_goal_raw;
  ddmsl_pkg::ramp_t  left_step;
  ddmsl_pkg::ramp_t  right_step;
  ddmsl_pkg::ramp_t  left_next;
  ddmsl_pkg::ramp_t  right_next;
  logic [15:0]       duty_rom [256];

  logic              sample_fire;
  logic              left_stepped;
  logic              right_neutral;
  logic              levels_shown;

  genvar             gi;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_tick  = (opcode == ddmsl_pkg::OP_TICK);

  assign vert_c   = $signed({2'b00, vertical} - {2'b00, ddmsl_pkg::JOY_CENTER});
  assign horiz_c  = $signed({2'b00, horizontal} - {2'b00, ddmsl_pkg::JOY_CENTER});
  assign mix_sum  = vert_c + horiz_c;
  assign mix_diff = vert_c - horiz_c;

  // Constant duty table, one entry per motor level.
  for (gi = 0; gi < 256; gi++) begin : g_duty_rom
    assign duty_rom[gi] = ddmsl_pkg::duty_of(gi);
  end

  ddmsl_goal u_goal_left (
    .cfg   (cfg),
    .mixed (mix_sum),
    .goal  (left_goal_next)
  );

  ddmsl_goal u_goal_right (
    .cfg   (cfg),
    .mixed (mix_diff),
    .goal  (right_goal_raw)
  );

  ddmsl_ramp u_ramp_left (
    .goal  (left_goal),
    .level (left_current),
    .dwell (left_dwell),
    .step  (left_step)
  );

  ddmsl_ramp u_ramp_right (
    .goal  (right_goal),
    .level (right_current),
    .dwell (right_dwell),
    .step  (right_step)
  );

  // A sample leaves levels and dwells alone and reports no step.
  always_comb begin
    left_next  = '{update: 1'b0, level: left_current, dwell: left_dwell};
    right_next = '{update: 1'b0, level: right_current, dwell: right_dwell};
    if (is_tick) begin
      left_next  = left_step;
      right_next = right_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bias     <= 8'd0;
      cfg.offset   <= 8'd0;
      cfg.speed_lo <= ddmsl_pkg::MIN_SPEED_RESET;
      cfg.speed_hi <= ddmsl_pkg::MAX_SPEED_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ddmsl_pkg::REG_SPEED_BIAS:   cfg.bias     <= cfg_data;
        ddmsl_pkg::REG_SPEED_OFFSET: cfg.offset   <= cfg_data;
        ddmsl_pkg::REG_MIN_SPEED:    cfg.speed_lo <= cfg_data;
        ddmsl_pkg::REG_MAX_SPEED:    cfg.speed_hi <= cfg_data[6:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_current  <= ddmsl_pkg::LEVEL_NEUTRAL;
      right_current <= ddmsl_pkg::LEVEL_NEUTRAL;
      left_goal     <= ddmsl_pkg::LEVEL_NEUTRAL;
      right_goal    <= ddmsl_pkg::LEVEL_NEUTRAL;
      left_dwell    <= 5'd0;
      right_dwell   <= 5'd0;
    end else if (in_fire) begin
      if (is_tick) begin
        left_current  <= left_step.level;
        right_current <= right_step.level;
        left_dwell    <= left_step.dwell;
        right_dwell   <= right_step.dwell;
      end else begin
        left_goal  <= left_goal_next;
        right_goal <= ~right_goal_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; loaded only when an item is taken, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_update  <= left_next.update;
      right_update <= right_next.update;
      left_level   <= left_next.level;
      right_level  <= right_next.level;
      left_duty    <= duty_rom[left_next.level];
      right_duty   <= duty_rom[right_next.level];
    end
  end

  assign sample_fire   = in_fire && !is_tick;
  assign left_stepped  = in_fire && is_tick && left_step.update;
  assign right_neutral = in_fire && is_tick && right_step.update &&
                         (right_step.level == ddmsl_pkg::LEVEL_NEUTRAL);
  assign levels_shown  = (left_level == left_current) && (right_level == right_current);

`include "diff_drive_mixer_slew_limiter_core_assert.svh"

  `DDMSL_ASSERT_NEXT(a_step_moves, clk, rst, left_stepped, left_current != $past(left_current))
  `DDMSL_ASSERT_NEXT(a_sample_holds, clk, rst, sample_fire, $stable({left_current, right_current}))
  `DDMSL_ASSERT_NEXT(a_dwell_starts, clk, rst, right_neutral, right_dwell == ddmsl_pkg::DWELL_TICKS)
  `DDMSL_ASSERT_NOW(a_level_matches_state, clk, rst, out_valid && !in_fire, levels_shown)

endmodule

>>> bench/tb_diff_drive_mixer_slew_limiter_core.sv
// Self-checking testbench for diff_drive_mixer_slew_limiter_core: joystick samples and
// ramp ticks are checked against a behavioral predictor of the mixer and motor slew.
// Depends on ddmsl_pkg and the core RTL only.
module tb_diff_drive_mixer_slew_limiter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int NUM_PHASES   = 8;
  localparam int HOLD_CYCLES  = 60;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_e;

  typedef struct packed {
    logic        left_update;
    logic [15:0] left_duty;
    logic        right_update;
    logic [15:0] right_duty;
    logic [7:0]  left_level;
    logic [7:0]  right_level;
  } motor_result_t;

  typedef struct packed {
    logic          op;
    logic [7:0]    vert;
    logic [7:0]    horiz;
    logic          typed;
    motor_result_t want;
  } stim_row_t;

  typedef struct {
    logic [7:0] bias;
    logic [7:0] offset;
    logic [7:0] min_spd;
    logic [7:0] max_spd;
    flow_e      mode;
    bit         hold;
    int         items;
  } drive_phase_t;

  localparam motor_result_t WANT_NEUTRAL =
    '{1'b0, 16'd6522, 1'b0, 16'd6522, 8'd127, 8'd127};
  localparam motor_result_t WANT_RIGHT_UP =
    '{1'b0, 16'd6522, 1'b1, 16'd6548, 8'd127, 8'd128};
  localparam motor_result_t WANT_RIGHT_HELD =
    '{1'b0, 16'd6522, 1'b0, 16'd6548, 8'd127, 8'd128};
  localparam motor_result_t NO_WANT = '0;

  // The right motor's goal is 255 minus its mixed goal, so a centered stick sets it to 128.
  localparam stim_row_t DIRECTED_ROWS [22] = '{
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b1, WANT_NEUTRAL},
    '{ddmsl_pkg::OP_SAMPLE, 8'd124, 8'd124, 1'b1, WANT_NEUTRAL},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b1, WANT_RIGHT_UP},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b1, WANT_RIGHT_HELD},
    '{ddmsl_pkg::OP_SAMPLE, 8'd255, 8'd255, 1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd255, 8'd255, 1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_SAMPLE, 8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_SAMPLE, 8'd255, 8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_SAMPLE, 8'd0,   8'd255, 1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_SAMPLE, 8'd124, 8'd140, 1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_SAMPLE, 8'd124, 8'd127, 1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT},
    '{ddmsl_pkg::OP_SAMPLE, 8'd155, 8'd124, 1'b0, NO_WANT},
    '{ddmsl_pkg::OP_TICK,   8'd0,   8'd0,   1'b0, NO_WANT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = ddmsl_pkg::REG_SPEED_BIAS;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = ddmsl_pkg::OP_SAMPLE;
  logic [7:0]  vertical = 8'd0;
  logic [7:0]  horizontal = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        left_update;
  logic [15:0] left_duty;
  logic        right_update;
  logic [15:0] right_duty;
  logic [7:0]  left_level;
  logic [7:0]  right_level;

  diff_drive_mixer_slew_limiter_core u_top (.*);

  always #1 clk = ~clk;

  // Predictor state: register copy, motor goals and slew state.
  ddmsl_pkg::cfg_t  speed_cfg = '{8'd0, 8'd0, ddmsl_pkg::MIN_SPEED_RESET,
                                  ddmsl_pkg::MAX_SPEED_RESET};
  logic [7:0]       left_target = ddmsl_pkg::LEVEL_NEUTRAL;
  logic [7:0]       right_target = ddmsl_pkg::LEVEL_NEUTRAL;
  ddmsl_pkg::ramp_t left_slew = '{1'b0, ddmsl_pkg::LEVEL_NEUTRAL, 5'd0};
  ddmsl_pkg::ramp_t right_slew = '{1'b0, ddmsl_pkg::LEVEL_NEUTRAL, 5'd0};
  motor_result_t    pending_results [$];

  flow_e        flow = FLOW_FREE;
  int           errors = 0;
  int           cycles = 0;
  int           hold_req = 0;
  int           hold_taken = 0;
  int           hold_left = 0;
  drive_phase_t phases [NUM_PHASES];

  function automatic int gap_pct(bit sink);
    case (flow)
      FLOW_SRC_GAPS:    return sink ? 0 : 53;
      FLOW_SINK_STALLS: return sink ? 53 : 0;
      FLOW_BOTH:        return 11;
      default:          return 0;
    endcase
  endfunction

  function automatic logic [7:0] goal_from_mix(int mixed);
    int spd;
    int lo;
    int hi;
    int ofs;
    int bias_val;
    spd = (mixed * 100) >>> 9;
    lo = $signed(speed_cfg.speed_lo);
    hi = int'(speed_cfg.speed_hi);
    ofs = $signed(speed_cfg.offset);
    bias_val = $signed(speed_cfg.bias);
    if (spd > -3 && spd < 3) spd = 0;
    if (spd > 5 || spd < -5) spd = spd + bias_val;
    // The offset pushes away from zero but never carries a speed across it.
    if (spd > 0) begin
      spd = spd + ofs;
      if (spd < 0) spd = 0;
    end else if (spd < 0) begin
      spd = spd - ofs;
      if (spd > 0) spd = 0;
    end
    if (spd > hi) spd = hi;
    else if (spd < lo) spd = lo;
    return 8'(int'(ddmsl_pkg::LEVEL_NEUTRAL) - spd);
  endfunction

  function automatic ddmsl_pkg::ramp_t slew_step(logic [7:0] goal, ddmsl_pkg::ramp_t st);
    ddmsl_pkg::ramp_t nx;
    nx = st;
    nx.update = 1'b0;
    if (goal == st.level) return nx;
    if (st.dwell != 5'd0) begin
      nx.dwell = st.dwell - 5'd1;
      return nx;
    end
    nx.level = (st.level < goal) ? st.level + 8'd1 : st.level - 8'd1;
    if (nx.level == ddmsl_pkg::LEVEL_NEUTRAL) nx.dwell = ddmsl_pkg::DWELL_TICKS;
    nx.update = 1'b1;
    return nx;
  endfunction

  function automatic logic [15:0] pwm_compare(logic [7:0] level);
    longint unsigned full;
    longint unsigned count;
    full = (64'd1 << ddmsl_pkg::PWM_BITS) - 64'd1;
    count = (64'd10000 + 64'd78 * level) * ddmsl_pkg::PWM_HZ * full / 64'd10000000;
    if (count > full) count = full;
    if (count > 64'hFFFF) count = 64'hFFFF;
    return count[15:0];
  endfunction

  function automatic motor_result_t predict_item(logic op, logic [7:0] v, logic [7:0] h);
    motor_result_t r;
    int v_c;
    int h_c;
    v_c = int'(v) - int'(ddmsl_pkg::JOY_CENTER);
    h_c = int'(h) - int'(ddmsl_pkg::JOY_CENTER);
    if (op == ddmsl_pkg::OP_SAMPLE) begin
      left_target = goal_from_mix(v_c + h_c);
      right_target = 8'd255 - goal_from_mix(v_c - h_c);
      left_slew.update = 1'b0;
      right_slew.update = 1'b0;
    end else begin
      left_slew = slew_step(left_target, left_slew);
      right_slew = slew_step(right_target, right_slew);
    end
    r.left_update = left_slew.update;
    r.left_duty = pwm_compare(left_slew.level);
    r.right_update = right_slew.update;
    r.right_duty = pwm_compare(right_slew.level);
    r.left_level = left_slew.level;
    r.right_level = right_slew.level;
    return r;
  endfunction

  function automatic logic [7:0] joystick_axis();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 8'($urandom);
    if (pick < 85) return 8'(int'(ddmsl_pkg::JOY_CENTER) - 10 + int'($urandom_range(20)));
    case ($urandom_range(2))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return ddmsl_pkg::JOY_CENTER;
    endcase
  endfunction

  task automatic offer_item(logic op, logic [7:0] v, logic [7:0] h, logic typed,
                            motor_result_t typed_want);
    motor_result_t want;
    while ($urandom_range(99) < gap_pct(1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    vertical <= v;
    horizontal <= h;
    do @(posedge clk); while (!in_ready);
    want = predict_item(op, v, h);
    pending_results.push_back(typed ? typed_want : want);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_regs(drive_phase_t ph);
    cfg_write <= 1'b1;
    cfg_index <= ddmsl_pkg::REG_SPEED_BIAS;
    cfg_data <= ph.bias;
    @(posedge clk);
    cfg_index <= ddmsl_pkg::REG_SPEED_OFFSET;
    cfg_data <= ph.offset;
    @(posedge clk);
    cfg_index <= ddmsl_pkg::REG_MIN_SPEED;
    cfg_data <= ph.min_spd;
    @(posedge clk);
    cfg_index <= ddmsl_pkg::REG_MAX_SPEED;
    cfg_data <= ph.max_spd;
    @(posedge clk);
    cfg_write <= 1'b0;
    speed_cfg.bias = ph.bias;
    speed_cfg.offset = ph.offset;
    speed_cfg.speed_lo = ph.min_spd;
    speed_cfg.speed_hi = ph.max_spd[6:0];
  endtask

  task automatic compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic check_result();
    motor_result_t want;
    if (pending_results.size() == 0) begin
      $error("result arrived with no item pending");
      errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("left_update", 16'(want.left_update), 16'(left_update));
    compare_field("left_duty", want.left_duty, left_duty);
    compare_field("right_update", 16'(want.right_update), 16'(right_update));
    compare_field("right_duty", want.right_duty, right_duty);
    compare_field("left_level", 16'(want.left_level), 16'(left_level));
    compare_field("right_level", 16'(want.right_level), 16'(right_level));
  endtask

  // Result side: checks each taken result, then decides the next ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_taken != hold_req) begin
      hold_taken = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= gap_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL diff_drive_mixer_slew_limiter_core");
      $finish;
    end
  end

  initial begin
    stim_row_t  row;
    logic       op;
    logic [7:0] v;
    logic [7:0] h;
    phases[0] = '{8'd0, 8'd0, ddmsl_pkg::MIN_SPEED_RESET, {1'b0, ddmsl_pkg::MAX_SPEED_RESET},
                  FLOW_FREE, 1'b0, 60};
    phases[1] = '{8'd100, 8'h9C, 8'h80, 8'd127, FLOW_SRC_GAPS, 1'b0, 75};
    phases[2] = '{8'h9C, 8'd100, 8'd0, 8'd0, FLOW_SINK_STALLS, 1'b0, 75};
    phases[3] = '{8'd7, 8'd3, 8'hCE, 8'd60, FLOW_BOTH, 1'b0, 75};
    phases[4] = '{8'(int'($urandom_range(200)) - 100), 8'(int'($urandom_range(200)) - 100),
                  8'(-int'($urandom_range(128))), 8'($urandom_range(127)),
                  FLOW_FREE, 1'b1, 75};
    // Minimum above maximum: the upper clamp is tried first.
    phases[5] = '{8'hFD, 8'hFB, 8'd20, 8'd10, FLOW_SRC_GAPS, 1'b0, 60};
    phases[6] = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  FLOW_SINK_STALLS, 1'b0, 75};
    phases[7] = '{8'(int'($urandom_range(20)) - 10), 8'(int'($urandom_range(20)) - 10),
                  8'(-int'($urandom_range(128))), 8'($urandom_range(127)),
                  FLOW_BOTH, 1'b0, 75};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      offer_item(row.op, row.vert, row.horiz, row.typed, row.want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        settle();
        program_regs(phases[p]);
      end
      flow = phases[p].mode;
      if (phases[p].hold) hold_req++;
      for (int n = 0; n < phases[p].items; n++) begin
        // Ticks dominate so that levels travel far and run into the dwell.
        if ($urandom_range(99) < 80) begin
          op = ddmsl_pkg::OP_TICK;
          v = 8'($urandom);
          h = 8'($urandom);
        end else begin
          op = ddmsl_pkg::OP_SAMPLE;
          v = joystick_axis();
          h = joystick_axis();
        end
        offer_item(op, v, h, 1'b0, NO_WANT);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS diff_drive_mixer_slew_limiter_core");
    end else begin
      $display("FAIL diff_drive_mixer_slew_limiter_core");
    end
    $finish;
  end

endmodule

>>> diff_drive_mixer_slew_limiter_core.f
+incdir+rtl/core
rtl/core/ddmsl_pkg.sv
rtl/core/ddmsl_goal.sv
rtl/core/ddmsl_ramp.sv
rtl/core/diff_drive_mixer_slew_limiter_core.sv
bench/tb_diff_drive_mixer_slew_limiter_core.sv
